// File: hdl/smpg_pkg.sv
`timescale 1ns / 1ps
package smpg_pkg;

    localparam int unsigned MAX_DIM    = 4096;
    localparam int unsigned MAX_LEVELS = 13;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned IDX_W      = 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SRGB_MODE    = 2'd2;
    localparam logic [IDX_W-1:0] REG_INVERT_GLOSS = 2'd3;

    typedef logic [15:0] t_dec_tab [256];
    typedef logic [31:0] t_thr_tab [256];

    function automatic logic [63:0] f_mul32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 32;
    endfunction

    function automatic logic [63:0] f_lin32(input int unsigned n);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] res;
        int          b;
        w = 64'd0;
        if (n <= 20) begin
            res = (64'(100 * n) << 32) / 64'd658920;
        end else begin
            u = (64'(1000 * n + 28050) << 32) / 64'd538050;
            if (u > 64'hFFFF_FFFF) begin
                u = 64'hFFFF_FFFF;
            end
            v = f_mul32(u, u);
            for (b = 31; b >= 0; b--) begin
                t = w | (64'd1 << b);
                p = f_mul32(t, t);
                p = f_mul32(p, t);
                p = f_mul32(p, t);
                p = f_mul32(p, t);
                if (p <= v) begin
                    w = t;
                end
            end
            res = f_mul32(v, w);
        end
        return res;
    endfunction

    function automatic t_dec_tab f_dec_tab();
        t_dec_tab    tab;
        logic [63:0] d;
        int          c;
        for (c = 0; c < 256; c++) begin
            d = (f_lin32(2 * c) + 64'h8000) >> 16;
            tab[c] = (d > 64'd65535) ? 16'hFFFF : d[15:0];
        end
        return tab;
    endfunction

    function automatic t_thr_tab f_thr_tab();
        t_thr_tab    tab;
        logic [63:0] d;
        int          c;
        for (c = 0; c < 256; c++) begin
            d = (c == 0) ? 64'd0 : f_lin32(2 * c - 1);
            tab[c] = d[31:0];
        end
        return tab;
    endfunction

    localparam t_dec_tab DEC_TAB = f_dec_tab();
    localparam t_thr_tab THR_TAB = f_thr_tab();

endpackage

// File: hdl/srgb_mipmap_pyramid_generator_unit.sv
`timescale 1ns / 1ps
// The level-0 result is registered from the accepted input; each lower level adds
// row store reads plus a pass through the shared averaging unit (8-step threshold
// search per colour channel) with sRGB on, or a rounded plain average with it off.
// A new pixel is taken only in the idle state, once the previous cascade is emitted.
// Reset: synchronous, active low; sizes 1x1, sRGB on, no inversion, all positions zero.
module srgb_mipmap_pyramid_generator_unit #(
    parameter int unsigned MAX_DIM    = smpg_pkg::MAX_DIM,
    parameter int unsigned MAX_LEVELS = smpg_pkg::MAX_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smpg_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [smpg_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_red, in_green, in_blue, in_alpha
    input  logic [31:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // mip_level, pixel_x, pixel_y, out_red, out_green, out_blue, out_alpha, zero pad
    output logic [63:0]                 m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int unsigned SZ_W   = $clog2(MAX_DIM + 1);
    localparam int unsigned CW     = $clog2(MAX_DIM);
    localparam int unsigned LV_W   = $clog2(MAX_LEVELS);
    localparam int unsigned LVN_W  = $clog2(MAX_LEVELS + 1);
    localparam int unsigned SLOTS  = 2 * MAX_DIM;
    localparam int unsigned AW     = $clog2(SLOTS);
    localparam int unsigned BASE_W = $clog2(SLOTS + MAX_LEVELS) + 1;

    typedef enum logic [2:0] {S_IDLE, S_EMIT, S_RD0, S_RD1, S_RD2, S_AVG, S_WAIT} t_state;

    t_state            r_state;
    logic [SZ_W-1:0]   r_img_w, r_img_h;
    logic              r_srgb, r_inv;
    logic [CW-1:0]     r_col [MAX_LEVELS];
    logic [CW-1:0]     r_row [MAX_LEVELS];
    logic [31:0]       r_hold [MAX_LEVELS];
    logic [LV_W-1:0]   r_l;
    logic [31:0]       r_pix;
    logic [CW-1:0]     r_x, r_y;
    logic [CW-1:0]     r_nx, r_ny;
    logic [SZ_W-1:0]   r_w, r_h;
    logic [BASE_W-1:0] r_base;
    logic [AW-1:0]     r_a0, r_a1;
    logic [31:0]       r_p00, r_p10, r_p01;
    logic              r_ovalid;
    logic [63:0]       r_odata;
    logic              r_olast;

    logic [LVN_W-1:0]  n_levels;
    logic [SZ_W-1:0]   m_dim;
    logic [CW-1:0]     c, y0, cx, cy;
    logic [SZ_W-1:0]   ce, ye, wn, hn, sx1, sy1, x2, y2;
    logic              n_cont, n_go, n_more;
    logic [BASE_W-1:0] s_wr, s_a0, s_a1;
    logic [AW-1:0]     a_wr, a_a0, a_a1, raddr;
    logic [SZ_W-1:0]   n_cfg;
    logic [31:0]       in_pix;
    logic              ram_we;
    logic [31:0]       ram_rdata;
    logic              avg_start, avg_done;
    logic [31:0]       avg_pix;

    function automatic logic [AW-1:0] f_slot(input logic [BASE_W-1:0] s);
        return (s >= BASE_W'(SLOTS)) ? AW'(SLOTS - 1) : s[AW-1:0];
    endfunction

    always_comb begin
        m_dim    = (r_img_w > r_img_h) ? r_img_w : r_img_h;
        n_levels = LVN_W'(1);
        for (int i = 0; i < int'(SZ_W); i++) begin
            if (m_dim[i]) begin
                n_levels = LVN_W'(i + 1);
            end
        end
        if (n_levels > LVN_W'(MAX_LEVELS)) begin
            n_levels = LVN_W'(MAX_LEVELS);
        end

        c   = r_col[r_l];
        y0  = r_row[r_l];
        ce  = SZ_W'(c);
        ye  = SZ_W'(y0);
        wn  = (r_w >> 1 == '0) ? SZ_W'(1) : r_w >> 1;
        hn  = (r_h >> 1 == '0) ? SZ_W'(1) : r_h >> 1;
        x2  = {ce[SZ_W-1:1], 1'b0};
        y2  = {ye[SZ_W-1:1], 1'b0};
        sx1 = (x2 + SZ_W'(1) < r_w) ? x2 + SZ_W'(1) : r_w - SZ_W'(1);
        sy1 = (y2 + SZ_W'(1) < r_h) ? y2 + SZ_W'(1) : r_h - SZ_W'(1);
        n_more = (LVN_W'(r_l) + LVN_W'(1)) < n_levels;
        n_cont = n_more && ((ce >> 1) < wn) && ((ye >> 1) < hn)
               && (ce == sx1) && (ye == sy1);
        cx  = (r_l == '0) ? c : r_x;
        cy  = (r_l == '0) ? y0 : r_y;
        n_go = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);

        s_wr = r_base + BASE_W'(ce);
        s_a0 = r_base + BASE_W'(x2);
        s_a1 = r_base + BASE_W'(sx1);
        a_wr = f_slot(s_wr);
        a_a0 = f_slot(s_a0);
        a_a1 = f_slot(s_a1);
        ram_we = n_go && n_more && !y0[0];
        raddr  = (r_state == S_RD0) ? r_a0 : r_a1;

        n_cfg = (i_cfg_wdata == '0) ? SZ_W'(1) : SZ_W'(i_cfg_wdata);
        if (32'(i_cfg_wdata) > 32'(MAX_DIM)) begin
            n_cfg = SZ_W'(MAX_DIM);
        end

        in_pix = s_axis_tdata;
        if (r_inv) begin
            in_pix[23:0] = ~s_axis_tdata[23:0];
        end
        avg_start = (r_state == S_AVG);
    end

    smpg_row_ram #(.DEPTH(SLOTS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (a_wr),
        .i_wdata (r_pix),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    smpg_avg_unit u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (avg_start),
        .i_srgb  (r_srgb),
        .i_p00   (r_p00),
        .i_p10   (r_p10),
        .i_p01   (r_p01),
        .i_p11   (r_pix),
        .o_done  (avg_done),
        .o_pix   (avg_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_img_w  <= SZ_W'(1);
            r_img_h  <= SZ_W'(1);
            r_srgb   <= 1'b1;
            r_inv    <= 1'b0;
            r_ovalid <= 1'b0;
            r_l      <= '0;
            for (int i = 0; i < int'(MAX_LEVELS); i++) begin
                r_col[i] <= '0;
                r_row[i] <= '0;
            end
        end else begin
            if (n_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smpg_pkg::REG_IMAGE_WIDTH, smpg_pkg::REG_IMAGE_HEIGHT: begin
                        if (i_cfg_idx == smpg_pkg::REG_IMAGE_WIDTH) begin
                            r_img_w <= n_cfg;
                        end else begin
                            r_img_h <= n_cfg;
                        end
                        for (int i = 0; i < int'(MAX_LEVELS); i++) begin
                            r_col[i] <= '0;
                            r_row[i] <= '0;
                        end
                    end
                    smpg_pkg::REG_SRGB_MODE:    r_srgb <= i_cfg_wdata[0];
                    smpg_pkg::REG_INVERT_GLOSS: r_inv  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pix   <= in_pix;
                        r_l     <= '0;
                        r_w     <= r_img_w;
                        r_h     <= r_img_h;
                        r_base  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_go) begin
                        r_olast  <= !n_cont;
                        r_odata  <= {4'd0, r_pix[31:24], r_pix[23:16], r_pix[15:8],
                                     r_pix[7:0], 12'(cy), 12'(cx), 4'(r_l)};
                        if (ce + SZ_W'(1) >= r_w) begin
                            r_col[r_l] <= '0;
                            r_row[r_l] <= (ye + SZ_W'(1) >= r_h) ? '0 : y0 + CW'(1);
                        end else begin
                            r_col[r_l] <= c + CW'(1);
                        end
                        if (n_more && !c[0]) begin
                            r_hold[r_l] <= r_pix;
                        end
                        r_nx  <= CW'(ce >> 1);
                        r_ny  <= CW'(ye >> 1);
                        r_a0  <= a_a0;
                        r_a1  <= a_a1;
                        r_p01 <= (sx1 == x2) ? r_pix : r_hold[r_l];
                        r_state <= n_cont ? S_RD0 : S_IDLE;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_p00   <= ram_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_p10   <= ram_rdata;
                    r_state <= S_AVG;
                end
                S_AVG: r_state <= S_WAIT;
                S_WAIT: begin
                    if (avg_done) begin
                        r_pix   <= avg_pix;
                        r_x     <= r_nx;
                        r_y     <= r_ny;
                        r_l     <= r_l + LV_W'(1);
                        r_w     <= wn;
                        r_h     <= hn;
                        r_base  <= r_base + BASE_W'(r_w);
                        r_state <= S_EMIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

// File: hdl/smpg_row_ram.sv
`timescale 1ns / 1ps
module smpg_row_ram #(
    parameter int unsigned DEPTH = 2 * smpg_pkg::MAX_DIM
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/smpg_avg_unit.sv
`timescale 1ns / 1ps
module smpg_avg_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_srgb,
    input  logic [31:0] i_p00,
    input  logic [31:0] i_p10,
    input  logic [31:0] i_p01,
    input  logic [31:0] i_p11,
    output logic        o_done,
    output logic [31:0] o_pix
);

    typedef enum logic [1:0] {A_IDLE, A_SUM, A_SRCH} t_state;

    t_state      r_state;
    logic [31:0] r_q0, r_q1, r_q2, r_q3;
    logic        r_srgb;
    logic [1:0]  r_k;
    logic [2:0]  r_bit;
    logic [7:0]  r_code;
    logic [31:0] r_avg;
    logic [31:0] r_res;
    logic        r_done;

    logic [7:0]  c0, c1, c2, c3;
    logic [17:0] n_sum;
    logic [9:0]  n_csum;
    logic [7:0]  n_t;
    logic [7:0]  n_code;

    always_comb begin
        c0     = r_q0[8*r_k +: 8];
        c1     = r_q1[8*r_k +: 8];
        c2     = r_q2[8*r_k +: 8];
        c3     = r_q3[8*r_k +: 8];
        n_sum  = 18'(smpg_pkg::DEC_TAB[c0]) + 18'(smpg_pkg::DEC_TAB[c1])
               + 18'(smpg_pkg::DEC_TAB[c2]) + 18'(smpg_pkg::DEC_TAB[c3]);
        n_csum = 10'(c0) + 10'(c1) + 10'(c2) + 10'(c3) + 10'd2;
        n_t    = r_code | (8'd1 << r_bit);
        n_code = (smpg_pkg::THR_TAB[n_t] <= r_avg) ? n_t : r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_done <= (r_state == A_SUM) && (r_k == 2'd3);
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_q0    <= i_p00;
                        r_q1    <= i_p10;
                        r_q2    <= i_p01;
                        r_q3    <= i_p11;
                        r_srgb  <= i_srgb;
                        r_k     <= 2'd0;
                        r_state <= A_SUM;
                    end
                end
                A_SUM: begin
                    if (r_srgb && r_k != 2'd3) begin
                        r_avg   <= {n_sum[17:0], 14'd0};
                        r_code  <= 8'd0;
                        r_bit   <= 3'd7;
                        r_state <= A_SRCH;
                    end else begin
                        r_res[8*r_k +: 8] <= n_csum[9:2];
                        if (r_k == 2'd3) begin
                            r_state <= A_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                A_SRCH: begin
                    if (r_bit == 3'd0) begin
                        r_res[8*r_k +: 8] <= n_code;
                        if (r_k == 2'd3) begin
                            r_state <= A_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= A_SUM;
                        end
                    end else begin
                        r_code <= n_code;
                        r_bit  <= r_bit - 3'd1;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_pix  = r_res;

endmodule

// File: tb/smpg_checker.sv
`timescale 1ns / 1ps
module smpg_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [smpg_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [smpg_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [31:0]                i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [63:0]                i_out_data,
    input  logic                       i_out_last,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int unsigned SLOTS = 2 * smpg_pkg::MAX_DIM;

    typedef struct packed {
        logic [3:0]  level;
        logic [11:0] px;
        logic [11:0] py;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } t_mip_pixel;

    t_mip_pixel  mip_pixels_due[$];
    logic [15:0] lin_code[256];
    logic [63:0] code_edge[256];
    logic [31:0] row_px[SLOTS];
    logic [31:0] col_px[smpg_pkg::MAX_LEVELS];
    int unsigned col_pos[smpg_pkg::MAX_LEVELS];
    int unsigned row_pos[smpg_pkg::MAX_LEVELS];
    int unsigned lev_w[smpg_pkg::MAX_LEVELS];
    int unsigned lev_h[smpg_pkg::MAX_LEVELS];
    int unsigned lev_base[smpg_pkg::MAX_LEVELS];
    int unsigned level_count;
    int unsigned width_q;
    int unsigned height_q;
    logic        srgb_q;
    logic        invert_q;
    int          errors;

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 32;
    endfunction

    function automatic logic [63:0] srgb_to_lin(input int unsigned n);
        logic [63:0] u;
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] pw;
        if (n <= 20) return (64'(100 * n) << 32) / 64'd658920;
        u = (64'(1000 * n + 28050) << 32) / 64'd538050;
        if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
        sq = fx_mul(u, u);
        root = 0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            pw = fx_mul(fx_mul(fx_mul(fx_mul(trial, trial), trial), trial), trial);
            if (pw <= sq) root = trial;
        end
        return fx_mul(sq, root);
    endfunction

    function automatic void recompute_levels();
        int unsigned m;
        int unsigned acc;
        m = (width_q > height_q) ? width_q : height_q;
        level_count = 0;
        acc = 0;
        while (m != 0) begin
            level_count++;
            m >>= 1;
        end
        if (level_count > smpg_pkg::MAX_LEVELS) level_count = smpg_pkg::MAX_LEVELS;
        if (level_count < 1) level_count = 1;
        for (int l = 0; l < smpg_pkg::MAX_LEVELS; l++) begin
            if (l == 0) begin
                lev_w[0] = width_q;
                lev_h[0] = height_q;
            end else begin
                lev_w[l] = (lev_w[l-1] / 2 != 0) ? lev_w[l-1] / 2 : 1;
                lev_h[l] = (lev_h[l-1] / 2 != 0) ? lev_h[l-1] / 2 : 1;
            end
            lev_base[l] = acc;
            acc += lev_w[l];
            col_pos[l] = 0;
            row_pos[l] = 0;
        end
    endfunction

    function automatic int unsigned slot_of(input int unsigned l, input int unsigned c);
        int unsigned i;
        i = lev_base[l] + c;
        return (i < SLOTS) ? i : SLOTS - 1;
    endfunction

    function automatic logic [31:0] box_average(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        logic [63:0] acc;
        int unsigned code;
        res = 0;
        for (int k = 0; k < 4; k++) begin
            if (srgb_q && k < 3) begin
                acc = 64'(lin_code[a[8*k +: 8]]) + lin_code[b[8*k +: 8]] +
                      lin_code[c[8*k +: 8]] + lin_code[d[8*k +: 8]];
                acc = acc << 14;
                code = 0;
                while (code < 255 && code_edge[code + 1] <= acc) code++;
            end else begin
                code = (32'(a[8*k +: 8]) + b[8*k +: 8] + c[8*k +: 8] + d[8*k +: 8] + 2) >> 2;
            end
            res[8*k +: 8] = code[7:0];
        end
        return res;
    endfunction

    function automatic t_mip_pixel make_pixel(input int unsigned l, input int unsigned x,
                                              input int unsigned y, input logic [31:0] p);
        t_mip_pixel r;
        r.level = l[3:0];
        r.px = x[11:0];
        r.py = y[11:0];
        r.red = p[7:0];
        r.green = p[15:8];
        r.blue = p[23:16];
        r.alpha = p[31:24];
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void cascade_pixel(input logic [31:0] din);
        t_mip_pixel  outs[smpg_pkg::MAX_LEVELS];
        logic [31:0] pix;
        logic [31:0] p00;
        logic [31:0] p10;
        logic [31:0] p01;
        int unsigned l;
        int unsigned n;
        int unsigned c;
        int unsigned y0;
        int unsigned x;
        int unsigned y;
        int unsigned sx1;
        int unsigned sy1;
        pix = din;
        if (invert_q) pix[23:0] = ~pix[23:0];
        l = 0;
        n = 0;
        forever begin
            c = col_pos[l];
            y0 = row_pos[l];
            if (l == 0) begin
                outs[n] = make_pixel(0, c, y0, pix);
                n++;
            end
            col_pos[l]++;
            if (col_pos[l] >= lev_w[l]) begin
                col_pos[l] = 0;
                row_pos[l]++;
                if (row_pos[l] >= lev_h[l]) row_pos[l] = 0;
            end
            if (l + 1 >= level_count) break;
            if (y0[0] == 1'b0) row_px[slot_of(l, c)] = pix;
            if (c[0] == 1'b0) col_px[l] = pix;
            x = c / 2;
            y = y0 / 2;
            if (x >= lev_w[l+1] || y >= lev_h[l+1]) break;
            sx1 = (2 * x + 1 < lev_w[l]) ? 2 * x + 1 : lev_w[l] - 1;
            sy1 = (2 * y + 1 < lev_h[l]) ? 2 * y + 1 : lev_h[l] - 1;
            if (c != sx1 || y0 != sy1) break;
            p00 = row_px[slot_of(l, 2 * x)];
            p10 = row_px[slot_of(l, sx1)];
            p01 = (sx1 == 2 * x) ? pix : col_px[l];
            pix = box_average(p00, p10, p01, pix);
            l++;
            outs[n] = make_pixel(l, x, y, pix);
            n++;
        end
        outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) mip_pixels_due = {mip_pixels_due, outs[i]};
    endfunction

    initial begin
        for (int c = 0; c < 256; c++) begin
            logic [63:0] d;
            d = (srgb_to_lin(2 * c) + 64'h8000) >> 16;
            lin_code[c] = (d > 64'd65535) ? 16'hFFFF : d[15:0];
            code_edge[c] = (c == 0) ? 64'd0 : srgb_to_lin(2 * c - 1);
        end
        errors = 0;
    end

    always @(posedge i_clk) begin
        t_mip_pixel  got;
        t_mip_pixel  want;
        int unsigned v;
        if (!i_rst_n) begin
            width_q = 1;
            height_q = 1;
            srgb_q = 1'b1;
            invert_q = 1'b0;
            recompute_levels();
        end else begin
            if (i_cfg_we) begin
                v = i_cfg_wdata;
                if (v == 0) v = 1;
                if (v > smpg_pkg::MAX_DIM) v = smpg_pkg::MAX_DIM;
                case (i_cfg_idx)
                    smpg_pkg::REG_IMAGE_WIDTH: begin
                        width_q = v;
                        recompute_levels();
                    end
                    smpg_pkg::REG_IMAGE_HEIGHT: begin
                        height_q = v;
                        recompute_levels();
                    end
                    smpg_pkg::REG_SRGB_MODE: srgb_q = i_cfg_wdata[0];
                    smpg_pkg::REG_INVERT_GLOSS: invert_q = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) cascade_pixel(i_in_data);
            if (i_out_valid && i_out_ready) begin
                got = make_pixel(i_out_data[3:0], i_out_data[15:4], i_out_data[27:16],
                                 i_out_data[59:28]);
                got.last = i_out_last;
                if (mip_pixels_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected output transaction: %h", got);
                end else begin
                    want = mip_pixels_due.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "mismatch: l %0d/%0d x %0d/%0d y %0d/%0d rgba %h/%h last %b/%b",
                                want.level, got.level, want.px, got.px, want.py, got.py,
                                {want.red, want.green, want.blue, want.alpha},
                                {got.red, got.green, got.blue, got.alpha},
                                want.last, got.last);
                    end
                end
            end
        end
    end

    assign o_mismatches = errors;
    assign o_pending = mip_pixels_due.size();
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [smpg_pkg::IDX_W-1:0] i_cfg_idx;
    logic [smpg_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [63:0]                m_axis_tdata;
    logic                       m_axis_tlast;
    int                         mismatches;
    int                         pending;
    int                         pixels_sent;
    int                         quiet_cycles;
    logic                       calm;
    logic                       hold_req;
    logic                       hold_done;

    srgb_mipmap_pyramid_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    smpg_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_axis_tready = calm ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [smpg_pkg::IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val[smpg_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [31:0] d);
        while (!calm && $urandom_range(99) < 18) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = d;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input logic srgb, input logic inv, input int unsigned n);
        drain();
        write_reg(smpg_pkg::REG_IMAGE_WIDTH, w);
        write_reg(smpg_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(smpg_pkg::REG_SRGB_MODE, srgb);
        write_reg(smpg_pkg::REG_INVERT_GLOSS, inv);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = smpg_pkg::REG_IMAGE_WIDTH;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        pixels_sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset geometry 1x1, then extremes of codes and modes
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        drain();
        write_reg(smpg_pkg::REG_IMAGE_WIDTH, 2);
        write_reg(smpg_pkg::REG_IMAGE_HEIGHT, 2);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_FF00);
        run_phase(3, 3, 1'b0, 1'b1, 9);
        run_phase(1, 2, 1'b1, 1'b1, 2);
        run_phase(0, 8191, 1'b0, 1'b0, 4);

        // random images, mostly small
        while (pixels_sent < 385) begin
            if (pixels_sent > 120 && pixels_sent < 220) calm = 1'b1;
            else calm = 1'b0;
            if (pixels_sent > 250 && !hold_done) begin
                // hold the receiver off while the sender keeps offering
                hold_done = 1'b1;
                hold_req = 1'b1;
                for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
            end
            case ($urandom_range(19))
                0: begin w = 4096; h = $urandom_range(1, 3); n = 24; end
                1: begin w = 1; h = 4096; n = 16; end
                2: begin w = $urandom_range(1, 16); h = 1; n = w; end
                default: begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(1, 9);
                    n = w * h * $urandom_range(1, 2);
                    if ($urandom_range(4) == 0) n = $urandom_range(1, w * h);
                end
            endcase
            run_phase(w, h, $urandom_range(1), $urandom_range(1), n);
        end
        drain();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: srgb_mipmap_pyramid_generator_unit.f
hdl/smpg_pkg.sv
hdl/smpg_row_ram.sv
hdl/smpg_avg_unit.sv
hdl/srgb_mipmap_pyramid_generator_unit.sv
tb/smpg_checker.sv
tb/tb_top.sv
